### hdl/fpcs_pkg.sv
// shared types and codes of the process scheduler
package fpcs_pkg;

    localparam logic [2:0] OP_IDLE      = 3'd0;
    localparam logic [2:0] OP_PREEMPT   = 3'd1;
    localparam logic [2:0] OP_YIELD     = 3'd2;
    localparam logic [2:0] OP_TERMINATE = 3'd3;
    localparam logic [2:0] OP_WAKE      = 3'd4;

    localparam logic [1:0] ACT_DISPATCH = 2'd0;
    localparam logic [1:0] ACT_PREEMPT  = 2'd1;
    localparam logic [1:0] ACT_NONE     = 2'd2;

    localparam logic [1:0] PST_READY      = 2'd0;
    localparam logic [1:0] PST_WAITING    = 2'd1;
    localparam logic [1:0] PST_TERMINATED = 2'd2;

    localparam logic [1:0] REG_PRIORITY_MODE = 2'd0;
    localparam logic [1:0] REG_CPU_COUNT     = 2'd1;
    localparam logic [1:0] REG_TIME_SLICE    = 2'd2;

    // one process entry, as held in the ready queue and the cpu slots
    typedef struct packed {
        logic [7:0] id;
        logic [3:0] prio;
    } entry_t;

    // result beat, first field in the highest bits
    typedef struct packed {
        logic        queue_overflow;
        logic [15:0] slice_out;
        logic [1:0]  released_state;
        logic [7:0]  released_id;
        logic        released_valid;
        logic [7:0]  dispatch_id;
        logic        dispatch_valid;
        logic [2:0]  target_cpu;
        logic [1:0]  action;
    } result_t;

endpackage

### hdl/fpcs_ram.sv
// single-port-write, single-port-read entry memory with registered read data
module fpcs_ram #(
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  fpcs_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output fpcs_pkg::entry_t rdata
);
    import fpcs_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/fifo_priority_cpu_scheduler.sv
// top level: event sequencer over the ready queue and cpu slot memories
//
// Takes one scheduler event per input beat and returns one result beat. The
// ready queue (QUEUE_DEPTH entries in arrival order) and the per-cpu running
// slots each live in a memory with one read and one write port; the running
// valid bits are flip-flops. Events are handled one at a time. The queue
// memory is read one entry per cycle when an event dispatches from a non-empty
// queue: FIFO mode reads the head only and priority mode scans every queued
// entry. Every entry behind the chosen one then moves down a place. A
// priority-mode wake scans the cpu slot memory at one cpu per cycle. A
// finished result waits in an output register while the next event is taken.
// While a result still waits there, the next result is held back.
module fifo_priority_cpu_scheduler #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_CPUS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // event beat: opcode[2:0], cpu_index[5:3], proc_id[13:6], proc_priority[17:14]
    input  logic [23:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // result beat: action[1:0], target_cpu[4:2], dispatch_valid[5], dispatch_id[13:6],
    // released_valid[14], released_id[22:15], released_state[24:23],
    // slice_out[40:25], queue_overflow[41]
    output logic [47:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import fpcs_pkg::*;

    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int CNW = $clog2(MAX_CPUS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_REL,
        S_TAKE,
        S_SCAN,
        S_SHIFT,
        S_WSCAN,
        S_DONE
    } state_t;

    state_t          state_reg, state_next;
    logic [2:0]      op_reg, op_next;
    logic [2:0]      cpu_reg, cpu_next;
    logic [7:0]      pid_reg, pid_next;
    logic [3:0]      pprio_reg, pprio_next;
    logic [QCW-1:0]  rc_reg, rc_next;
    logic [MAX_CPUS-1:0] valid_reg, valid_next;
    logic [QCW-1:0]  ridx_reg, ridx_next;
    logic [QCW-1:0]  didx_reg, didx_next;
    logic            dv_reg, dv_next;
    logic [3:0]      best_prio_reg, best_prio_next;
    logic [7:0]      best_id_reg, best_id_next;
    logic [QCW-1:0]  best_idx_reg, best_idx_next;
    logic [CNW-1:0]  cidx_reg, cidx_next;
    logic [CNW-1:0]  cdidx_reg, cdidx_next;
    logic [3:0]      low_prio_reg, low_prio_next;
    logic [CNW-1:0]  low_cpu_reg, low_cpu_next;
    result_t         res_reg, res_next;
    result_t         out_reg, out_next;
    logic            out_valid_reg, out_valid_next;
    logic            prio_mode_reg, prio_mode_next;
    logic [3:0]      cpus_used_reg, cpus_used_next;
    logic [15:0]     time_slice_reg, time_slice_next;

    logic            q_we;
    logic [QW-1:0]   q_waddr;
    entry_t          q_wdata;
    logic [QW-1:0]   q_raddr;
    entry_t          q_rdata;
    logic            r_we;
    logic [CW-1:0]   r_waddr;
    entry_t          r_wdata;
    logic [CW-1:0]   r_raddr;
    entry_t          r_rdata;

    logic [CNW-1:0]  ncpu;
    logic [CW-1:0]   cpu_addr;
    logic [QCW-1:0]  scan_limit;
    logic            take_best;
    logic            take_low;

    fpcs_ram #(.DEPTH(QUEUE_DEPTH), .AW(QW)) u_ready_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    fpcs_ram #(.DEPTH(MAX_CPUS), .AW(CW)) u_slot_ram (
        .clk   (clk),
        .we    (r_we),
        .waddr (r_waddr),
        .wdata (r_wdata),
        .raddr (r_raddr),
        .rdata (r_rdata)
    );

    assign ncpu = (32'(cpus_used_reg) > MAX_CPUS) ? CNW'(MAX_CPUS) : CNW'(cpus_used_reg);
    assign cpu_addr = CW'(cpu_reg);
    // fifo mode only looks at the head of the queue
    assign scan_limit = prio_mode_reg ? rc_reg : QCW'(1);
    // strict compare keeps the oldest entry among equal priorities
    assign take_best = dv_reg && ((didx_reg == '0) || (q_rdata.prio > best_prio_reg));
    assign take_low  = dv_reg && ((cdidx_reg == '0) || (r_rdata.prio < low_prio_reg));

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_reg};

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cpu_next        = cpu_reg;
        pid_next        = pid_reg;
        pprio_next      = pprio_reg;
        rc_next         = rc_reg;
        valid_next      = valid_reg;
        ridx_next       = ridx_reg;
        didx_next       = didx_reg;
        dv_next         = dv_reg;
        best_prio_next  = take_best ? q_rdata.prio : best_prio_reg;
        best_id_next    = take_best ? q_rdata.id : best_id_reg;
        best_idx_next   = take_best ? didx_reg : best_idx_reg;
        cidx_next       = cidx_reg;
        cdidx_next      = cdidx_reg;
        low_prio_next   = low_prio_reg;
        low_cpu_next    = low_cpu_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        prio_mode_next  = prio_mode_reg;
        cpus_used_next  = cpus_used_reg;
        time_slice_next = time_slice_reg;

        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = '0;
        r_we    = 1'b0;
        r_waddr = cpu_addr;
        r_wdata = '0;
        r_raddr = cpu_addr;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PRIORITY_MODE: prio_mode_next  = cfg_data[0];
                REG_CPU_COUNT:     cpus_used_next  = cfg_data[3:0];
                REG_TIME_SLICE:    time_slice_next = cfg_data;
                default: ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next           = s_tdata[2:0];
                    cpu_next          = s_tdata[5:3];
                    pid_next          = s_tdata[13:6];
                    pprio_next        = s_tdata[17:14];
                    res_next          = '0;
                    res_next.action   = ACT_NONE;
                    state_next        = S_DECODE;
                end
            end

            S_DECODE:
            begin
                if (op_reg == OP_WAKE)
                begin
                    if (32'(rc_reg) < QUEUE_DEPTH)
                    begin
                        q_we    = 1'b1;
                        q_waddr = QW'(rc_reg);
                        q_wdata = '{id: pid_reg, prio: pprio_reg};
                        rc_next = rc_reg + QCW'(1);
                        if (prio_mode_reg && (ncpu != '0))
                        begin
                            cidx_next  = '0;
                            dv_next    = 1'b0;
                            state_next = S_WSCAN;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        res_next.queue_overflow = 1'b1;
                        state_next = S_DONE;
                    end
                end
                else if ((op_reg > OP_WAKE) || (32'(cpu_reg) >= 32'(ncpu)))
                begin
                    state_next = S_DONE;
                end
                else if ((op_reg != OP_IDLE) && valid_reg[cpu_addr])
                begin
                    state_next = S_REL;
                end
                else
                begin
                    state_next = S_TAKE;
                end
            end

            S_REL:
            begin
                res_next.released_valid = 1'b1;
                res_next.released_id    = r_rdata.id;
                case (op_reg)
                    OP_PREEMPT:
                    begin
                        res_next.released_state = PST_READY;
                        if (32'(rc_reg) < QUEUE_DEPTH)
                        begin
                            q_we    = 1'b1;
                            q_waddr = QW'(rc_reg);
                            q_wdata = r_rdata;
                            rc_next = rc_reg + QCW'(1);
                        end
                        else
                        begin
                            res_next.queue_overflow = 1'b1;
                        end
                    end
                    OP_YIELD:     res_next.released_state = PST_WAITING;
                    default:      res_next.released_state = PST_TERMINATED;
                endcase
                valid_next[cpu_addr] = 1'b0;
                state_next = S_TAKE;
            end

            S_TAKE:
            begin
                res_next.action     = ACT_DISPATCH;
                res_next.target_cpu = cpu_reg;
                res_next.slice_out  = time_slice_reg;
                if (rc_reg == '0)
                begin
                    valid_next[cpu_addr] = 1'b0;
                    state_next = S_DONE;
                end
                else
                begin
                    ridx_next  = '0;
                    dv_next    = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_SCAN:
            begin
                if (ridx_reg < scan_limit)
                begin
                    q_raddr   = QW'(ridx_reg);
                    dv_next   = 1'b1;
                    didx_next = ridx_reg;
                    ridx_next = ridx_reg + QCW'(1);
                end
                else
                begin
                    dv_next = 1'b0;
                end
                if (dv_reg && (didx_reg == scan_limit - QCW'(1)))
                begin
                    r_we    = 1'b1;
                    r_waddr = cpu_addr;
                    r_wdata = '{id: best_id_next, prio: best_prio_next};
                    valid_next[cpu_addr]    = 1'b1;
                    res_next.dispatch_valid = 1'b1;
                    res_next.dispatch_id    = best_id_next;
                    // close the gap left by the chosen entry
                    ridx_next  = best_idx_next + QCW'(1);
                    dv_next    = 1'b0;
                    state_next = S_SHIFT;
                end
            end

            S_SHIFT:
            begin
                if (dv_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = QW'(didx_reg - QCW'(1));
                    q_wdata = q_rdata;
                end
                if (ridx_reg < rc_reg)
                begin
                    q_raddr   = QW'(ridx_reg);
                    dv_next   = 1'b1;
                    didx_next = ridx_reg;
                    ridx_next = ridx_reg + QCW'(1);
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        rc_next    = rc_reg - QCW'(1);
                        state_next = S_DONE;
                    end
                end
            end

            S_WSCAN:
            begin
                if (take_low)
                begin
                    low_prio_next = r_rdata.prio;
                    low_cpu_next  = cdidx_reg;
                end
                if (cidx_reg < ncpu)
                begin
                    if (!valid_reg[cidx_reg[CW-1:0]])
                    begin
                        // an idle cpu will pick the process up, no preempt
                        dv_next    = 1'b0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        r_raddr    = cidx_reg[CW-1:0];
                        dv_next    = 1'b1;
                        cdidx_next = cidx_reg;
                        cidx_next  = cidx_reg + CNW'(1);
                    end
                end
                else
                begin
                    dv_next = 1'b0;
                    if (!dv_reg)
                    begin
                        if (low_prio_reg < pprio_reg)
                        begin
                            res_next.action     = ACT_PREEMPT;
                            res_next.target_cpu = 3'(low_cpu_reg);
                        end
                        state_next = S_DONE;
                    end
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            cpu_reg        <= '0;
            pid_reg        <= '0;
            pprio_reg      <= '0;
            rc_reg         <= '0;
            valid_reg      <= '0;
            ridx_reg       <= '0;
            didx_reg       <= '0;
            dv_reg         <= 1'b0;
            best_prio_reg  <= '0;
            best_id_reg    <= '0;
            best_idx_reg   <= '0;
            cidx_reg       <= '0;
            cdidx_reg      <= '0;
            low_prio_reg   <= '0;
            low_cpu_reg    <= '0;
            res_reg        <= '0;
            out_reg        <= '0;
            out_valid_reg  <= 1'b0;
            prio_mode_reg  <= 1'b0;
            cpus_used_reg  <= 4'd1;
            time_slice_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            cpu_reg        <= cpu_next;
            pid_reg        <= pid_next;
            pprio_reg      <= pprio_next;
            rc_reg         <= rc_next;
            valid_reg      <= valid_next;
            ridx_reg       <= ridx_next;
            didx_reg       <= didx_next;
            dv_reg         <= dv_next;
            best_prio_reg  <= best_prio_next;
            best_id_reg    <= best_id_next;
            best_idx_reg   <= best_idx_next;
            cidx_reg       <= cidx_next;
            cdidx_reg      <= cdidx_next;
            low_prio_reg   <= low_prio_next;
            low_cpu_reg    <= low_cpu_next;
            res_reg        <= res_next;
            out_reg        <= out_next;
            out_valid_reg  <= out_valid_next;
            prio_mode_reg  <= prio_mode_next;
            cpus_used_reg  <= cpus_used_next;
            time_slice_reg <= time_slice_next;
        end
    end

endmodule

### dv/fpcs_checker.sv
// checker: predicts scheduler results from accepted events and compares result beats
module fpcs_checker #(
    parameter int QUEUE_DEPTH = 16,
    parameter int MAX_CPUS    = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [23:0] s_tdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] m_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          dispatches,
    output int          forced,
    output int          drops
);
    import fpcs_pkg::*;

    // shadow copy of the scheduler state
    entry_t      ready_q [QUEUE_DEPTH];
    int          ready_len;
    logic        busy [MAX_CPUS];
    entry_t      on_cpu [MAX_CPUS];
    logic        mode_prio;
    logic [3:0]  cpus_reg;
    logic [15:0] slice_reg;

    result_t     expected_results [$];
    result_t     predicted;
    result_t     got;

    int fails     = 0;
    int queued    = 0;
    int n_results = 0;
    int n_disp    = 0;
    int n_forced  = 0;
    int n_drops   = 0;

    assign fail_count   = fails;
    assign pending      = queued;
    assign results_seen = n_results;
    assign dispatches   = n_disp;
    assign forced       = n_forced;
    assign drops        = n_drops;

    function automatic logic ready_push(input entry_t e);
        if (ready_len >= QUEUE_DEPTH)
            return 1'b0;
        ready_q[ready_len] = e;
        ready_len++;
        return 1'b1;
    endfunction

    task automatic schedule_event(input logic [2:0] op, input logic [2:0] cpu,
                                  input entry_t woken, output result_t r);
        int     ncpu;
        int     pick;
        int     low_cpu;
        logic   any_idle;
        logic   [3:0] low;
        entry_t chosen;
        r = '0;
        r.action = ACT_NONE;
        ncpu = (cpus_reg > MAX_CPUS) ? MAX_CPUS : int'(cpus_reg);
        if (op == OP_WAKE) begin
            r.queue_overflow = !ready_push(woken);
            if (!r.queue_overflow && mode_prio && ncpu > 0) begin
                any_idle = 1'b0;
                low_cpu  = 0;
                low      = '0;
                // first idle cpu ends the scan; else track the lowest priority, first on ties
                for (int i = 0; i < ncpu && !any_idle; i++) begin
                    if (!busy[i])
                        any_idle = 1'b1;
                    else if (i == 0 || on_cpu[i].prio < low) begin
                        low     = on_cpu[i].prio;
                        low_cpu = i;
                    end
                end
                if (!any_idle && low < woken.prio) begin
                    r.action     = ACT_PREEMPT;
                    r.target_cpu = low_cpu[2:0];
                end
            end
        end else if (op <= OP_WAKE && int'(cpu) < ncpu) begin
            if (op != OP_IDLE && busy[cpu]) begin
                r.released_valid = 1'b1;
                r.released_id    = on_cpu[cpu].id;
                if (op == OP_PREEMPT) begin
                    r.released_state = PST_READY;
                    if (!ready_push(on_cpu[cpu]))
                        r.queue_overflow = 1'b1;
                end else begin
                    r.released_state = (op == OP_YIELD) ? PST_WAITING : PST_TERMINATED;
                end
            end
            // idle on a busy cpu simply overwrites the slot
            busy[cpu]    = 1'b0;
            r.action     = ACT_DISPATCH;
            r.target_cpu = cpu;
            r.slice_out  = slice_reg;
            if (ready_len > 0) begin
                pick = 0;
                if (mode_prio) begin
                    for (int i = 1; i < ready_len; i++)
                        if (ready_q[i].prio > ready_q[pick].prio)
                            pick = i;
                end
                chosen = ready_q[pick];
                for (int i = pick; i + 1 < ready_len; i++)
                    ready_q[i] = ready_q[i + 1];
                ready_len--;
                busy[cpu]        = 1'b1;
                on_cpu[cpu]      = chosen;
                r.dispatch_valid = 1'b1;
                r.dispatch_id    = chosen.id;
            end
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            ready_len = 0;
            for (int i = 0; i < MAX_CPUS; i++)
                busy[i] = 1'b0;
            mode_prio = 1'b0;
            cpus_reg  = 4'd1;
            slice_reg = '0;
            expected_results.delete();
            queued = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_PRIORITY_MODE: mode_prio = cfg_data[0];
                    REG_CPU_COUNT:     cpus_reg  = cfg_data[3:0];
                    REG_TIME_SLICE:    slice_reg = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                schedule_event(s_tdata[2:0], s_tdata[5:3], {s_tdata[13:6], s_tdata[17:14]},
                               predicted);
                expected_results.push_back(predicted);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[41:0];
                if (expected_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, expected none, got %h",
                             $time, m_tdata);
                    fails++;
                end else begin
                    predicted = expected_results.pop_front();
                    check_field("action",         predicted.action,         got.action);
                    check_field("target_cpu",     predicted.target_cpu,     got.target_cpu);
                    check_field("dispatch_valid", predicted.dispatch_valid, got.dispatch_valid);
                    check_field("dispatch_id",    predicted.dispatch_id,    got.dispatch_id);
                    check_field("released_valid", predicted.released_valid, got.released_valid);
                    check_field("released_id",    predicted.released_id,    got.released_id);
                    check_field("released_state", predicted.released_state, got.released_state);
                    check_field("slice_out",      predicted.slice_out,      got.slice_out);
                    check_field("queue_overflow", predicted.queue_overflow, got.queue_overflow);
                    n_results++;
                    if (predicted.action == ACT_DISPATCH && predicted.dispatch_valid)
                        n_disp++;
                    if (predicted.action == ACT_PREEMPT)
                        n_forced++;
                    if (predicted.queue_overflow)
                        n_drops++;
                end
            end
            queued = expected_results.size();
        end
    end

endmodule

### dv/tb_fifo_priority_cpu_scheduler.sv
// testbench top: drives scheduler events and register writes, gives the verdict
module tb_fifo_priority_cpu_scheduler;
    import fpcs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int NUM_PHASES  = 8;

    logic        clk = 1'b0;
    logic        rst_n;
    logic [23:0] s_tdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int fail_count;
    int pending;
    int results_seen;
    int dispatches;
    int forced;
    int drops;

    int   events_sent    = 0;
    int   cycles         = 0;
    logic calm           = 1'b1;
    logic long_hold_done = 1'b0;

    // per phase: mode, cpu count, slice (negative picks one at random), wake share, events
    int phase_mode  [NUM_PHASES] = '{0, 1, 1, 0, 1, 1, 0, 1};
    int phase_cpus  [NUM_PHASES] = '{1, 8, 3, 8, 15, 0, 4, 2};
    int phase_slice [NUM_PHASES] = '{0, 65535, -1, 1, -1, -1, -1, -1};
    int phase_wake  [NUM_PHASES] = '{50, 55, 80, 70, 55, 50, 85, 40};
    int phase_items [NUM_PHASES] = '{190, 210, 190, 190, 210, 60, 190, 210};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    fifo_priority_cpu_scheduler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fpcs_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tdata      (s_tdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tdata      (m_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .dispatches   (dispatches),
        .forced       (forced),
        .drops        (drops)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("TEST FAILED");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none during a calm stretch
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_event(input logic [2:0] op, input logic [2:0] cpu,
                              input logic [7:0] id, input logic [3:0] prio);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = {6'd0, prio, id, cpu, op};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    // result side: random ready runs and stalls, plus one long hold-off
    initial
    begin
        int unsigned run;
        int unsigned stall;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (!long_hold_done && events_sent >= 400)
            begin
                long_hold_done = 1'b1;
                m_tready = 1'b0;
                repeat (400) @(negedge clk);
            end
            else if (calm)
            begin
                m_tready = 1'b1;
                @(negedge clk);
            end
            else
            begin
                run = $urandom_range(1, 12);
                m_tready = 1'b1;
                repeat (run) @(negedge clk);
                stall = pick_gap();
                if (stall != 0)
                begin
                    m_tready = 1'b0;
                    repeat (stall) @(negedge clk);
                end
            end
        end
    end

    initial
    begin
        int unsigned rv;
        int unsigned val;
        int          ncpu;
        logic [2:0]  op;
        logic [2:0]  cpu;
        logic [7:0]  id;
        logic [3:0]  prio;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_PRIORITY_MODE;
        cfg_data  = '0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: fifo, one cpu, zero slice
        send_event(OP_IDLE, 3'd0, 8'h00, 4'h0);
        send_event(OP_WAKE, 3'd0, 8'h01, 4'h0);
        send_event(OP_YIELD, 3'd1, 8'h00, 4'h0);

        wait_idle();
        write_reg(REG_PRIORITY_MODE, 16'd1);
        write_reg(REG_CPU_COUNT, 16'd2);
        write_reg(REG_TIME_SLICE, 16'hFFFF);
        send_event(OP_IDLE, 3'd0, 8'h00, 4'h0);
        send_event(OP_WAKE, 3'd7, 8'hFF, 4'hF);
        send_event(OP_WAKE, 3'd0, 8'h00, 4'h0);
        send_event(OP_IDLE, 3'd1, 8'h00, 4'h0);
        // both cpus are busy: a more urgent wake asks to preempt cpu 0
        send_event(OP_WAKE, 3'd0, 8'h80, 4'h8);
        send_event(OP_PREEMPT, 3'd0, 8'h00, 4'h0);
        // equal priority must not preempt
        send_event(OP_WAKE, 3'd0, 8'h7F, 4'h8);
        send_event(OP_YIELD, 3'd1, 8'h00, 4'h0);
        send_event(OP_WAKE, 3'd5, 8'h33, 4'h0);
        // all queued priorities zero
        send_event(OP_TERMINATE, 3'd0, 8'h00, 4'h0);
        send_event(OP_TERMINATE, 3'd1, 8'h00, 4'h0);
        send_event(OP_IDLE, 3'd0, 8'h00, 4'h0);
        send_event(OP_TERMINATE, 3'd0, 8'h00, 4'h0);
        // idle cpu with an empty queue, bad cpu index, bad opcodes, then a busy preempt
        send_event(OP_PREEMPT, 3'd0, 8'h00, 4'h0);
        send_event(OP_YIELD, 3'd0, 8'h00, 4'h0);
        send_event(OP_TERMINATE, 3'd7, 8'h00, 4'h0);
        send_event(3'd5, 3'd0, 8'hA5, 4'h5);
        send_event(3'd6, 3'd1, 8'h5A, 4'hA);
        send_event(3'd7, 3'd7, 8'hFF, 4'hF);
        send_event(OP_PREEMPT, 3'd1, 8'h00, 4'h0);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            val = phase_mode[p];
            write_reg(REG_PRIORITY_MODE, val[15:0]);
            val = phase_cpus[p];
            write_reg(REG_CPU_COUNT, val[15:0]);
            val = (phase_slice[p] < 0) ? $urandom_range(0, 65535) : phase_slice[p];
            write_reg(REG_TIME_SLICE, val[15:0]);
            ncpu = (phase_cpus[p] > 8) ? 8 : phase_cpus[p];
            for (int n = 0; n < phase_items[p]; n++)
            begin
                calm = (n < 30);
                rv = $urandom_range(0, 99);
                if (rv < phase_wake[p])
                    op = OP_WAKE;
                else if (rv >= 98)
                begin
                    rv = $urandom_range(5, 7);
                    op = rv[2:0];
                end
                else
                begin
                    rv = $urandom_range(0, 99);
                    if (rv < 15)
                        op = OP_IDLE;
                    else if (rv < 50)
                        op = OP_PREEMPT;
                    else if (rv < 75)
                        op = OP_YIELD;
                    else
                        op = OP_TERMINATE;
                end
                // mostly cpus in use, now and then any index
                if (ncpu > 0 && $urandom_range(0, 9) != 0)
                    rv = $urandom_range(0, ncpu - 1);
                else
                    rv = $urandom_range(0, 7);
                cpu = rv[2:0];
                rv = $urandom_range(0, 255);
                id = rv[7:0];
                rv = $urandom_range(0, 15);
                prio = rv[3:0];
                send_event(op, cpu, id, prio);
            end
        end

        calm = 1'b1;
        wait_idle();
        repeat (40) @(negedge clk);
        $display("covered %0d events and %0d result beats over %0d register settings",
                 events_sent, results_seen, NUM_PHASES + 2);
        $display("of which %0d dispatches, %0d forced preemptions, %0d dropped pushes",
                 dispatches, forced, drops);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
hdl/fpcs_pkg.sv
hdl/fpcs_ram.sv
hdl/fifo_priority_cpu_scheduler.sv
dv/fpcs_checker.sv
dv/tb_fifo_priority_cpu_scheduler.sv
